/* sv/text_terminal_glyph_renderer_macros.svh */
// assertion macros shared by the glyph renderer modules
`ifndef TEXT_TERMINAL_GLYPH_RENDERER_MACROS_SVH
`define TEXT_TERMINAL_GLYPH_RENDERER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TTGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ttgr_pkg.sv */
// shared types, constants and helpers of the text terminal glyph renderer
package ttgr_pkg;

  localparam int DISPLAY_HEIGHT = 128;
  localparam int DISPLAY_WIDTH  = 128;
  localparam int CELL_W         = 6;
  localparam int CELL_H         = 8;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 6;
  localparam int GLYPH_SHIFT    = 2;
  localparam int GLYPH_SHIFT_BIT = 30;
  localparam int COORD_MAX      = 127;

  typedef logic [6:0]  coord_t;
  typedef logic [15:0] color_t;
  typedef logic [30:0] glyph_t;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_START  = 2'd3
  } kind_t;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_MOVE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WINDOW,
    ST_PIXEL,
    ST_FILL,
    ST_START
  } state_t;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam color_t FG_RESET = 16'hFFFF;
  localparam color_t BG_RESET = 16'h0000;

  typedef struct packed {
    kind_t  kind;
    coord_t x_first;
    coord_t y_first;
    coord_t x_last;
    coord_t y_last;
    color_t pixel_color;
    coord_t start_line;
    logic   last;
  } result_t;

  function automatic coord_t sat_coord(logic [7:0] v);
    return (v > 8'(COORD_MAX)) ? coord_t'(COORD_MAX) : v[6:0];
  endfunction

endpackage

/* sv/ttgr_out_stage.sv */
// output register of the result stream
`include "text_terminal_glyph_renderer_macros.svh"

module ttgr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ttgr_pkg::result_t d,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ttgr_pkg::result_t q
);
  import ttgr_pkg::*;

  logic valid;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      q <= d;
    end
  end

  `TTGR_ASSERT_IMP(a_load_only_when_free, load, free, "result loaded over an untaken beat")
  `TTGR_ASSERT_NXT(a_load_shows, load, m_tvalid && (q == $past(d)), "loaded result not shown")
  `TTGR_ASSERT_NXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(q),
                   "stalled beat changed")

endmodule

/* sv/text_terminal_glyph_renderer.sv */
// Text console for a 128x128 display: draws 6x8 character cells from upstream glyph
// words, keeps the cursor, and scrolls with background fills and start-line commands.
// A move or carriage return gives no beat. A printable character gives one window
// beat and 48 pixel beats, one per cycle through the single output register while the
// sink does not stall; a cell that wraps while scrolling adds a fill and a start-line
// beat. The pixel sequencer walks the cell with one bit-index adder. A newline gives
// no beat unless scrolling adds its fill and start-line beats. The next item is taken
// only once the sequencer is back to idle; the last beat may still be waiting.
`include "text_terminal_glyph_renderer_macros.svh"

module text_terminal_glyph_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // char_code, glyph_word, new_x, new_y, zero fill
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  // x_first, y_first, x_last, y_last, pixel_color, start_line, zero fill
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ttgr_pkg::*;

  state_t  state, state_next;
  coord_t  cursor_col, cursor_col_next;
  coord_t  cursor_row, cursor_row_next;
  logic    scroll_active, scroll_active_next;
  coord_t  top_line, top_line_next;
  glyph_t  glyph, glyph_next;
  logic [2:0] pix_r, pix_r_next;
  logic [2:0] pix_c, pix_c_next;
  color_t  fg_color, bg_color;

  opcode_t in_op;
  logic [7:0] in_char;
  glyph_t  in_glyph;
  coord_t  in_x, in_y;

  logic    load, free;
  result_t res, out_q;

  // newline arithmetic from the current row
  logic [7:0] nl_sum;
  logic [8:0] nl_check;
  logic       nl_over, nl_scroll;
  coord_t     nl_row;

  // cursor advance and wrap test
  logic [7:0] col_adv;
  logic [8:0] wrap_check;
  logic       wrap;

  // cell bottom, shared by window and fill
  coord_t     y_bottom;
  coord_t     x_right;

  // pixel bit selection
  logic [3:0] rr;
  logic [4:0] bit_idx;
  logic       pix_on, pixel_last;
  logic [7:0] top_sum;

  assign in_op    = opcode_t'(s_tuser);
  assign in_char  = s_tdata[7:0];
  assign in_glyph = s_tdata[38:8];
  assign in_x     = s_tdata[45:39];
  assign in_y     = s_tdata[52:46];

  assign cfg_ready = 1'b1;

  assign nl_sum    = {1'b0, cursor_row} + 8'(CELL_H);
  assign nl_check  = {1'b0, nl_sum} + 9'(CELL_H);
  assign nl_over   = nl_check > 9'(DISPLAY_HEIGHT);
  assign nl_row    = nl_over ? '0 : nl_sum[6:0];
  assign nl_scroll = scroll_active || nl_over;

  assign col_adv    = {1'b0, cursor_col} + 8'(CELL_W);
  assign wrap_check = {1'b0, col_adv} + 9'(CELL_W);
  assign wrap       = wrap_check > 9'(COORD_MAX);

  assign y_bottom = sat_coord({1'b0, cursor_row} + 8'(CELL_H - 1));
  assign x_right  = sat_coord({1'b0, cursor_col} + 8'(CELL_W - 1));

  // row within the 6-row glyph, after the optional shift down
  assign rr      = {1'b0, pix_r} - (glyph[GLYPH_SHIFT_BIT] ? 4'(GLYPH_SHIFT) : 4'd0);
  assign bit_idx = {pix_c[2:0], 2'b00} + {1'b0, pix_c[2:0], 1'b0} + {1'b0, rr};
  assign pix_on  = (pix_c < 3'(GLYPH_COLS)) && (rr < 4'(GLYPH_ROWS)) && glyph[bit_idx];
  assign pixel_last = (pix_r == 3'(CELL_H - 1)) && (pix_c == 3'(CELL_W - 1));

  assign top_sum = {1'b0, top_line} + 8'(CELL_H);

  always_comb begin
    state_next         = state;
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    scroll_active_next = scroll_active;
    top_line_next      = top_line;
    glyph_next         = glyph;
    pix_r_next         = pix_r;
    pix_c_next         = pix_c;
    load               = 1'b0;
    res                = '0;
    s_tready           = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          glyph_next = in_glyph;
          if (in_op == OP_MOVE) begin
            cursor_col_next = in_x;
            cursor_row_next = in_y;
          end else if (in_char == CHAR_CR) begin
            if (cursor_col >= 7'(CELL_W)) begin
              cursor_col_next = cursor_col - 7'(CELL_W);
            end
          end else if (in_char == CHAR_LF) begin
            cursor_col_next    = '0;
            cursor_row_next    = nl_row;
            scroll_active_next = nl_scroll;
            if (nl_scroll) begin
              state_next = ST_FILL;
            end
          end else begin
            state_next = ST_WINDOW;
          end
        end
      end
      ST_WINDOW: begin
        if (free) begin
          load        = 1'b1;
          res.kind    = KIND_WINDOW;
          res.x_first = cursor_col;
          res.y_first = cursor_row;
          res.x_last  = x_right;
          res.y_last  = y_bottom;
          pix_r_next  = '0;
          pix_c_next  = '0;
          state_next  = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (free) begin
          load            = 1'b1;
          res.kind        = KIND_PIXEL;
          res.pixel_color = pix_on ? fg_color : bg_color;
          res.last        = pixel_last && !(wrap && nl_scroll);
          if (pix_c == 3'(CELL_W - 1)) begin
            pix_c_next = '0;
            pix_r_next = pix_r + 3'd1;
          end else begin
            pix_c_next = pix_c + 3'd1;
          end
          if (pixel_last) begin
            if (wrap) begin
              cursor_col_next    = '0;
              cursor_row_next    = nl_row;
              scroll_active_next = nl_scroll;
              state_next         = nl_scroll ? ST_FILL : ST_IDLE;
            end else begin
              cursor_col_next = col_adv[6:0];
              state_next      = ST_IDLE;
            end
          end
        end
      end
      ST_FILL: begin
        if (free) begin
          load            = 1'b1;
          res.kind        = KIND_FILL;
          res.y_first     = cursor_row;
          res.x_last      = sat_coord(8'(DISPLAY_WIDTH - 1));
          res.y_last      = y_bottom;
          res.pixel_color = bg_color;
          state_next      = ST_START;
        end
      end
      ST_START: begin
        if (free) begin
          load           = 1'b1;
          res.kind       = KIND_START;
          top_line_next  = (top_sum >= 8'(DISPLAY_HEIGHT)) ?
                           7'(top_sum - 8'(DISPLAY_HEIGHT)) : top_sum[6:0];
          res.start_line = top_line_next;
          res.last       = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cursor_col    <= '0;
      cursor_row    <= '0;
      scroll_active <= 1'b0;
      top_line      <= '0;
      fg_color      <= FG_RESET;
      bg_color      <= BG_RESET;
    end else begin
      state         <= state_next;
      cursor_col    <= cursor_col_next;
      cursor_row    <= cursor_row_next;
      scroll_active <= scroll_active_next;
      top_line      <= top_line_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FG) begin
          fg_color <= cfg_data;
        end else begin
          bg_color <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    glyph <= glyph_next;
    pix_r <= pix_r_next;
    pix_c <= pix_c_next;
  end

  ttgr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .d        (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .q        (out_q)
  );

  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;
  assign m_tdata = {5'b0, out_q.start_line, out_q.pixel_color, out_q.y_last,
                    out_q.x_last, out_q.y_first, out_q.x_first};

  `TTGR_ASSERT_NXT(a_fill_then_start, load && (res.kind == KIND_FILL), state == ST_START,
                   "fill not followed by start line")
  `TTGR_ASSERT_NXT(a_last_ends_item, load && res.last, state == ST_IDLE,
                   "last beat did not end the item")
  `TTGR_ASSERT_NXT(a_window_starts_cell, load && (res.kind == KIND_WINDOW),
                   (state == ST_PIXEL) && (pix_r == 3'd0) && (pix_c == 3'd0),
                   "pixel walk not reset after window")

endmodule
